### rtl/core/bdac_pkg.sv
// ----------------------------------------------------------------------------
// bdac_pkg
// Shared constants and helpers for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package bdac_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int DIGIT_W        = 6;
    localparam logic [DIGIT_W-1:0] ASCII_ZERO = 6'd48;

    // front-to-back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Decimal digits of 2^bits - 1: floor(bits * log10(2)) + 1.
    // 1233/4096 is close enough to log10(2) over the supported range.
    function automatic int dec_digits(input int bits);
        int prod;
        begin
            prod = bits * 1233;
            return (prod >> 12) + 1;
        end
    endfunction

endpackage

### rtl/core/binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Unsigned binary to decimal ASCII digit stream, most significant first.
// ----------------------------------------------------------------------------
// Each accepted value produces its decimal digits as ASCII characters, MSD
// first, without leading zeros; zero gives a single '0'. last_digit marks the
// final character of each value. A nonzero value is shifted through the
// double-dabble shifter, then every decimal position of the widest value
// (10 for 32 bits) is examined: leading zeros are dropped and the rest are
// sent to the output register, which can stall. A zero value skips the shifter.
// A two-entry input queue lets new values be taken while a conversion runs.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii
    import bdac_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DIGIT_W-1:0]    digit_char,
    output logic                  last_digit
);

    logic                  q_valid;
    logic                  q_ready;
    logic [VALUE_BITS-1:0] q_value;
    logic                  q_zero;

    bdac_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .value    (value),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_value  (q_value),
        .q_zero   (q_zero)
    );

    bdac_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_value    (q_value),
        .q_zero     (q_zero),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .digit_char (digit_char),
        .last_digit (last_digit)
    );

endmodule

### rtl/core/bdac_front.sv
// ----------------------------------------------------------------------------
// bdac_front
// Input side: accepts values, flags zero, and queues them for the back end.
// ----------------------------------------------------------------------------
module bdac_front
    import bdac_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  q_valid,
    input  logic                  q_ready,
    output logic [VALUE_BITS-1:0] q_value,
    output logic                  q_zero
);

    logic [VALUE_BITS-1:0] val_mem [QUEUE_DEPTH];
    logic                  zero_mem [QUEUE_DEPTH];

    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    logic push, pop;

    assign in_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign push     = in_valid & in_ready;
    assign pop      = q_valid & q_ready;

    assign q_value = val_mem[rd_ptr_reg];
    assign q_zero  = zero_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            val_mem[wr_ptr_reg]  <= value;
            zero_mem[wr_ptr_reg] <= (value == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/core/bdac_back.sv
// ----------------------------------------------------------------------------
// bdac_back
// Conversion engine: double-dabble shifter, then digit emission MSD first
// with leading zeros dropped, into an output register.
// ----------------------------------------------------------------------------
module bdac_back
    import bdac_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  logic [VALUE_BITS-1:0] q_value,
    input  logic                  q_zero,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DIGIT_W-1:0]    digit_char,
    output logic                  last_digit
);

    localparam int NDIG  = dec_digits(VALUE_BITS);
    localparam int BCD_W = 4 * NDIG;
    localparam int CNT_W = $clog2(NDIG + 1);
    localparam int SH_W  = $clog2(VALUE_BITS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_EMIT
    } state_t;

    state_t                state_reg, state_next;
    logic [VALUE_BITS-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]      bcd_reg, bcd_next;
    logic [SH_W-1:0]       shcnt_reg, shcnt_next;
    logic [CNT_W-1:0]      dcnt_reg, dcnt_next;
    logic                  lead_reg, lead_next;
    logic                  out_valid_reg, out_valid_next;
    logic [DIGIT_W-1:0]    digit_reg, digit_next;
    logic                  last_reg, last_next;

    logic [BCD_W-1:0] bcd_adj;
    logic [3:0]       top_digit;
    logic             out_free;

    assign out_valid  = out_valid_reg;
    assign digit_char = digit_reg;
    assign last_digit = last_reg;

    assign top_digit = bcd_reg[BCD_W-1 -: 4];
    assign out_free  = !out_valid_reg || out_ready;
    assign q_ready   = (state_reg == ST_IDLE);

    // add-3 correction on every BCD digit before the shift
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        shcnt_next     = shcnt_reg;
        dcnt_next      = dcnt_reg;
        lead_next      = lead_reg;
        out_valid_next = out_valid_reg && !out_ready;
        digit_next     = digit_reg;
        last_next      = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    bin_next   = q_value;
                    bcd_next   = '0;
                    shcnt_next = SH_W'(VALUE_BITS);
                    lead_next  = 1'b1;
                    if (q_zero)
                    begin
                        // nothing to shift: a single '0'
                        dcnt_next  = CNT_W'(1);
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        dcnt_next  = CNT_W'(NDIG);
                        state_next = ST_SHIFT;
                    end
                end
            end

            ST_SHIFT:
            begin
                bcd_next   = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_BITS-1]};
                bin_next   = {bin_reg[VALUE_BITS-2:0], 1'b0};
                shcnt_next = shcnt_reg - 1'b1;
                if (shcnt_reg == SH_W'(1))
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (lead_reg && (top_digit == 4'd0) && (dcnt_reg != CNT_W'(1)))
                begin
                    // leading zero, drop it
                    bcd_next  = {bcd_reg[BCD_W-5:0], 4'd0};
                    dcnt_next = dcnt_reg - 1'b1;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    digit_next     = ASCII_ZERO + {2'b00, top_digit};
                    last_next      = (dcnt_reg == CNT_W'(1));
                    bcd_next       = {bcd_reg[BCD_W-5:0], 4'd0};
                    dcnt_next      = dcnt_reg - 1'b1;
                    lead_next      = 1'b0;
                    if (dcnt_reg == CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            digit_reg     <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            digit_reg     <= digit_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg   <= bin_next;
        bcd_reg   <= bcd_next;
        shcnt_reg <= shcnt_next;
        dcnt_reg  <= dcnt_next;
        lead_reg  <= lead_next;
    end

endmodule

### rtl/core/bdac_checker.sv
// ----------------------------------------------------------------------------
// bdac_checker
// Port-level checks on the converter's input and output streams.
// ----------------------------------------------------------------------------
module bdac_checker
    import bdac_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic [VALUE_BITS-1:0] value,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [DIGIT_W-1:0]    digit_char,
    input logic                  last_digit
);

    localparam int NDIG  = dec_digits(VALUE_BITS);
    localparam int CNT_W = $clog2(NDIG + 1);

    logic             mid_run_reg, mid_run_next;
    logic [CNT_W-1:0] run_cnt_reg, run_cnt_next;
    logic             out_xfer;

    assign out_xfer = out_valid && out_ready;

    always_comb
    begin
        mid_run_next = mid_run_reg;
        run_cnt_next = run_cnt_reg;
        if (out_xfer)
        begin
            mid_run_next = !last_digit;
            run_cnt_next = last_digit ? '0 : run_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_run_reg <= 1'b0;
            run_cnt_reg <= '0;
        end
        else
        begin
            mid_run_reg <= mid_run_next;
            run_cnt_reg <= run_cnt_next;
        end
    end

    // a stalled character holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(digit_char) && $stable(last_digit))
        else $error("output transaction changed while stalled");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (digit_char >= 6'd48) && (digit_char <= 6'd57))
        else $error("character is not a decimal digit");

    // only a lone zero may open a run with '0'
    a_no_lead_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !mid_run_reg && (digit_char == ASCII_ZERO) |-> last_digit)
        else $error("leading zero emitted");

    a_run_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer |-> (run_cnt_reg < CNT_W'(NDIG)))
        else $error("run longer than the widest value allows");

    a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(value))
        else $error("input transaction dropped or changed while stalled");

endmodule

bind binary_to_decimal_ascii bdac_checker #(.VALUE_BITS(VALUE_BITS)) u_bdac_checker (.*);
